[rtl/core/bed_pkg.sv]
// Boolean entropy decoder: shared types, function codes and constants.
// No dependencies; every other file in rtl/core imports this package.
package bed_pkg;

    localparam int FUNC_W   = 3;
    localparam int VALUE_W  = 16;
    localparam int BYTE_W   = 8;
    localparam int PROB_W   = 8;
    localparam int BITS_W   = 5;
    localparam int RESULT_W = 17;

    localparam int DEF_QUEUE_DEPTH = 16;
    localparam int DEF_MAX_BITS    = 16;
    localparam int CMD_DEPTH       = 4;

    localparam logic [PROB_W-1:0] PROB_HALF  = 8'd128;
    localparam logic [7:0]        RANGE_INIT = 8'd255;

    localparam logic [FUNC_W-1:0] FUNC_START  = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_PUSH   = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_BOOL   = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_LIT    = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_SIGNED = 3'd4;
    localparam logic [FUNC_W-1:0] FUNC_OPT    = 3'd5;

    typedef struct packed {
        logic [FUNC_W-1:0]  func;
        logic [VALUE_W-1:0] init_value;
        logic [BYTE_W-1:0]  data_byte;
        logic [PROB_W-1:0]  probability;
        logic [BITS_W-1:0]  bit_count;
    } in_item_t;

    typedef struct packed {
        logic signed [RESULT_W-1:0] result_value;
        logic                       byte_dropped;
        logic                       underrun;
    } out_item_t;

    typedef enum logic [1:0] {
        CMD_START = 2'd0,
        CMD_PUSH  = 2'd1,
        CMD_READ  = 2'd2,
        CMD_NONE  = 2'd3
    } cmd_kind_t;

    // One classified command as handed from the front to the back.
    typedef struct packed {
        cmd_kind_t          kind;
        logic [VALUE_W-1:0] init_value;
        logic [BYTE_W-1:0]  data_byte;
        logic [PROB_W-1:0]  prob;
        logic [BITS_W-1:0]  count;       // magnitude bools, already saturated
        logic               flag_first;  // leading flag bool gates the rest
        logic               sign_after;  // trailing sign bool
    } cmd_t;

endpackage

[rtl/core/bed_front.sv]
// Boolean entropy decoder front: classifies input beats into commands.
// Depends on bed_pkg.
module bed_front #(
    parameter int MAX_BITS = bed_pkg::DEF_MAX_BITS
) (
    input  bed_pkg::in_item_t s_item,
    input  logic              s_valid,
    output logic              s_ready,
    output bed_pkg::cmd_t     cmd,
    output logic              cmd_valid,
    input  logic              cmd_ready
);
    import bed_pkg::*;

    localparam logic [BITS_W-1:0] MAX_COUNT = BITS_W'(MAX_BITS);

    logic [BITS_W-1:0] sat_count;

    assign sat_count = (s_item.bit_count > MAX_COUNT) ? MAX_COUNT : s_item.bit_count;
    assign cmd_valid = s_valid;
    assign s_ready   = cmd_ready;

    always_comb begin
        cmd            = '0;
        cmd.kind       = CMD_NONE;
        cmd.init_value = s_item.init_value;
        cmd.data_byte  = s_item.data_byte;
        cmd.prob       = PROB_HALF;
        cmd.count      = sat_count;
        unique case (s_item.func)
            FUNC_START: begin
                cmd.kind = CMD_START;
            end
            FUNC_PUSH: begin
                cmd.kind = CMD_PUSH;
            end
            FUNC_BOOL: begin
                cmd.kind  = CMD_READ;
                cmd.prob  = s_item.probability;
                cmd.count = BITS_W'(1);
            end
            FUNC_LIT: begin
                cmd.kind = CMD_READ;
            end
            FUNC_SIGNED: begin
                cmd.kind       = CMD_READ;
                cmd.sign_after = 1'b1;
            end
            FUNC_OPT: begin
                cmd.kind       = CMD_READ;
                cmd.flag_first = 1'b1;
                cmd.sign_after = 1'b1;
            end
            default: begin
                cmd.kind = CMD_NONE;
            end
        endcase
    end

endmodule

[rtl/core/bed_cmd_fifo.sv]
// Boolean entropy decoder command queue between front and back.
// Depends on bed_pkg (cmd_t, CMD_DEPTH).
module bed_cmd_fifo (
    input  logic          aclk,
    input  logic          aresetn,
    input  bed_pkg::cmd_t wr_cmd,
    input  logic          wr_valid,
    output logic          wr_ready,
    output bed_pkg::cmd_t rd_cmd,
    output logic          rd_valid,
    input  logic          rd_ready
);
    import bed_pkg::*;

    localparam int PTR_W = $clog2(CMD_DEPTH);
    localparam logic [PTR_W:0] COUNT_FULL = (PTR_W+1)'(CMD_DEPTH);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(CMD_DEPTH - 1);

    cmd_t             slot_reg [CMD_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W:0]   count_reg;
    logic             do_wr;
    logic             do_rd;

    assign wr_ready = (count_reg != COUNT_FULL);
    assign rd_valid = (count_reg != '0);
    assign rd_cmd   = slot_reg[rd_ptr_reg];
    assign do_wr    = wr_valid && wr_ready;
    assign do_rd    = rd_valid && rd_ready;

    always_ff @(posedge aclk) begin
        if (do_wr) begin
            slot_reg[wr_ptr_reg] <= wr_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_wr) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (do_rd) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
            if (do_wr && !do_rd) begin
                count_reg <= count_reg + (PTR_W+1)'(1);
            end else if (do_rd && !do_wr) begin
                count_reg <= count_reg - (PTR_W+1)'(1);
            end
        end
    end

endmodule

[rtl/core/bed_back.sv]
// Boolean entropy decoder back: byte queue, one-bool-per-cycle arithmetic
// decoder with combinational normalization, result register. Depends on bed_pkg.
module bed_back #(
    parameter int QUEUE_DEPTH = bed_pkg::DEF_QUEUE_DEPTH,
    parameter int MAX_BITS    = bed_pkg::DEF_MAX_BITS
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  bed_pkg::cmd_t      cmd,
    input  logic               cmd_valid,
    output logic               cmd_ready,
    output bed_pkg::out_item_t m_item,
    output logic               m_valid,
    input  logic               m_ready
);
    import bed_pkg::*;

    localparam int QPTR_W = $clog2(QUEUE_DEPTH);
    localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);
    localparam int CNT_W  = $clog2(MAX_BITS + 1);
    localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(QUEUE_DEPTH);
    localparam logic [QPTR_W-1:0] HEAD_LAST = QPTR_W'(QUEUE_DEPTH - 1);
    localparam logic [FILL_W:0]   WRAP_SUM  = (FILL_W+1)'(QUEUE_DEPTH);

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_ACT  = 6'b000010,
        ST_FLAG = 6'b000100,
        ST_MAG  = 6'b001000,
        ST_SIGN = 6'b010000,
        ST_FIN  = 6'b100000
    } back_state_t;

    back_state_t          state_reg;
    cmd_t                 cmd_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic [RESULT_W-1:0]  acc_reg;
    logic                 dropped_reg;
    logic                 underrun_reg;
    out_item_t            out_reg;
    logic                 m_valid_reg;

    logic [VALUE_W-1:0]   code_value_reg;
    logic [7:0]           code_range_reg;
    logic [2:0]           shift_count_reg;
    logic [QPTR_W-1:0]    head_reg;
    logic [QPTR_W-1:0]    head_next;
    logic [FILL_W-1:0]    fill_reg;
    logic [FILL_W-1:0]    fill_next;

    logic [BYTE_W-1:0]    queue_mem [QUEUE_DEPTH];
    logic [BYTE_W-1:0]    rd_byte_reg;

    // bool datapath
    logic [15:0]          prod;
    logic [7:0]           split;
    logic [VALUE_W-1:0]   big;
    logic                 bool_bit;
    logic [7:0]           range_a;
    logic [VALUE_W-1:0]   value_a;
    logic [2:0]           norm_n;
    logic [3:0]           sc_sum;
    logic                 wrap;
    logic                 queue_empty;
    logic [BYTE_W-1:0]    fill_byte;
    logic [VALUE_W-1:0]   refill_word;
    logic [7:0]           range_norm;
    logic [VALUE_W-1:0]   value_norm;

    logic                 bool_en;
    logic                 push_en;
    logic                 refill_take;
    logic                 refill_under;
    logic                 out_free;
    logic [FILL_W:0]      tail_sum;
    logic [QPTR_W-1:0]    tail_addr;
    logic [CNT_W-1:0]     cmd_cnt;

    assign cmd_ready = (state_reg == ST_IDLE);
    assign m_item    = out_reg;
    assign m_valid   = m_valid_reg;
    assign out_free  = !m_valid_reg || m_ready;
    assign cmd_cnt   = CNT_W'(cmd.count);

    assign bool_en = (state_reg == ST_FLAG) || (state_reg == ST_MAG) || (state_reg == ST_SIGN);
    assign push_en = (state_reg == ST_ACT) && (cmd_reg.kind == CMD_PUSH)
                     && (fill_reg != FILL_FULL);

    // split = 1 + ((range - 1) * prob) / 256
    assign prod     = {8'd0, code_range_reg - 8'd1} * {8'd0, cmd_reg.prob};
    assign split    = prod[15:8] + 8'd1;
    assign big      = {split, 8'h00};
    assign bool_bit = (code_value_reg >= big);
    assign range_a  = bool_bit ? (code_range_reg - split) : split;
    assign value_a  = bool_bit ? (code_value_reg - big) : code_value_reg;

    // leading-zero count of the new range; range_a is never zero
    always_comb begin
        norm_n = 3'd0;
        for (int i = 0; i < 8; i++) begin
            if (range_a[i]) begin
                norm_n = 3'(7 - i);
            end
        end
    end

    // at most one byte boundary is crossed per bool; the byte lands after
    // the wrapping shift and moves up by the shifts that follow it
    assign sc_sum       = {1'b0, shift_count_reg} + {1'b0, norm_n};
    assign wrap         = sc_sum[3];
    assign queue_empty  = (fill_reg == '0);
    assign fill_byte    = queue_empty ? '0 : rd_byte_reg;
    assign refill_word  = {8'd0, fill_byte} << sc_sum[2:0];
    assign range_norm   = range_a << norm_n;
    assign value_norm   = (value_a << norm_n) | (wrap ? refill_word : '0);
    assign refill_take  = bool_en && wrap && !queue_empty;
    assign refill_under = bool_en && wrap && queue_empty;

    assign tail_sum  = (FILL_W+1)'(head_reg) + {1'b0, fill_reg};
    assign tail_addr = (tail_sum >= WRAP_SUM) ? QPTR_W'(tail_sum - WRAP_SUM)
                                              : QPTR_W'(tail_sum);

    always_comb begin
        head_next = head_reg;
        fill_next = fill_reg;
        if (refill_take) begin
            head_next = (head_reg == HEAD_LAST) ? '0 : head_reg + QPTR_W'(1);
            fill_next = fill_reg - FILL_W'(1);
        end else if (push_en) begin
            fill_next = fill_reg + FILL_W'(1);
        end
    end

    // byte queue; read port follows the next head, write-first on a match
    always_ff @(posedge aclk) begin
        if (push_en) begin
            queue_mem[tail_addr] <= cmd_reg.data_byte;
        end
        if (push_en && (tail_addr == head_next)) begin
            rd_byte_reg <= cmd_reg.data_byte;
        end else begin
            rd_byte_reg <= queue_mem[head_next];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            code_value_reg  <= '0;
            code_range_reg  <= RANGE_INIT;
            shift_count_reg <= '0;
            head_reg        <= '0;
            fill_reg        <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            head_reg <= head_next;
            fill_reg <= fill_next;
            if (bool_en) begin
                code_value_reg  <= value_norm;
                code_range_reg  <= range_norm;
                shift_count_reg <= sc_sum[2:0];
            end else if ((state_reg == ST_ACT) && (cmd_reg.kind == CMD_START)) begin
                code_value_reg  <= cmd_reg.init_value;
                code_range_reg  <= RANGE_INIT;
                shift_count_reg <= '0;
            end
            if ((state_reg == ST_FIN) && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (cmd_valid) begin
                        if (cmd.kind != CMD_READ) begin
                            state_reg <= ST_ACT;
                        end else if (cmd.flag_first) begin
                            state_reg <= ST_FLAG;
                        end else if (cmd_cnt != '0) begin
                            state_reg <= ST_MAG;
                        end else if (cmd.sign_after) begin
                            state_reg <= ST_SIGN;
                        end else begin
                            state_reg <= ST_FIN;
                        end
                    end
                end
                ST_ACT: begin
                    state_reg <= ST_FIN;
                end
                ST_FLAG: begin
                    if (!bool_bit) begin
                        state_reg <= ST_FIN;
                    end else if (cnt_reg != '0) begin
                        state_reg <= ST_MAG;
                    end else begin
                        state_reg <= ST_SIGN;
                    end
                end
                ST_MAG: begin
                    if (cnt_reg == CNT_W'(1)) begin
                        state_reg <= cmd_reg.sign_after ? ST_SIGN : ST_FIN;
                    end
                end
                ST_SIGN: begin
                    state_reg <= ST_FIN;
                end
                ST_FIN: begin
                    if (out_free) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // per-item payload, no reset needed
    always_ff @(posedge aclk) begin
        if ((state_reg == ST_IDLE) && cmd_valid) begin
            cmd_reg      <= cmd;
            cnt_reg      <= cmd_cnt;
            acc_reg      <= '0;
            dropped_reg  <= 1'b0;
            underrun_reg <= 1'b0;
        end else begin
            if (refill_under) begin
                underrun_reg <= 1'b1;
            end
            if ((state_reg == ST_ACT) && (cmd_reg.kind == CMD_PUSH) && !push_en) begin
                dropped_reg <= 1'b1;
            end
            if (state_reg == ST_MAG) begin
                acc_reg <= {acc_reg[RESULT_W-2:0], bool_bit};
                cnt_reg <= cnt_reg - CNT_W'(1);
            end
            if ((state_reg == ST_SIGN) && bool_bit) begin
                acc_reg <= '0 - acc_reg;
            end
        end
        if ((state_reg == ST_FIN) && out_free) begin
            out_reg.result_value <= $signed(acc_reg);
            out_reg.byte_dropped <= dropped_reg;
            out_reg.underrun     <= underrun_reg;
        end
    end

endmodule

[rtl/core/boolean_entropy_decoder_core.sv]
// Boolean entropy decoder, top level: front classifier, command queue, back engine.
// Depends on bed_pkg, bed_front, bed_cmd_fifo and bed_back.
//
// Usage:
//   s_valid/s_ready/s_item carry one beat per item: start (loads the 16-bit
//   code value, range 255), push (appends a byte to the byte queue), bool,
//   unsigned literal, signed and optional signed reads. m_valid/m_ready/m_item
//   return exactly one result beat per input beat, in order.
//   The back engine decodes one bool per cycle, normalization and byte
//   refill included. An item holds it from the idle state through its bool
//   states (flag, magnitude, sign) to the final state; start, push and unused
//   codes pass through the action state instead. That engine alone sets the
//   rate. An idle engine takes the command in the cycle after the input beat;
//   m_valid rises as the engine leaves its final state.
//   The four-entry command queue keeps s_ready high while the engine works
//   or while a result waits; s_ready drops only when that queue is full.
//   A stalled receiver holds the finished result in the output register and
//   stops the engine at its final cycle; queued commands wait.
//   Reset (aresetn low, synchronous) empties both queues, drops any pending
//   result, sets range 255 and clears the code value and shift count.
//   No clearing pass is needed: queued bytes are read only after writing.
module boolean_entropy_decoder_core #(
    parameter int QUEUE_DEPTH = bed_pkg::DEF_QUEUE_DEPTH,
    parameter int MAX_BITS    = bed_pkg::DEF_MAX_BITS
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  bed_pkg::in_item_t  s_item,
    input  logic               s_valid,
    output logic               s_ready,
    output bed_pkg::out_item_t m_item,
    output logic               m_valid,
    input  logic               m_ready
);
    import bed_pkg::*;

    cmd_t front_cmd;
    logic front_valid;
    logic fifo_wr_ready;
    cmd_t q_cmd;
    logic q_valid;
    logic back_ready;

    // classify the input beat
    bed_front #(
        .MAX_BITS (MAX_BITS)
    ) u_front (
        .s_item    (s_item),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .cmd       (front_cmd),
        .cmd_valid (front_valid),
        .cmd_ready (fifo_wr_ready)
    );

    // decouples acceptance from the engine
    bed_cmd_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_cmd   (front_cmd),
        .wr_valid (front_valid),
        .wr_ready (fifo_wr_ready),
        .rd_cmd   (q_cmd),
        .rd_valid (q_valid),
        .rd_ready (back_ready)
    );

    // decoder engine, byte queue and result register
    bed_back #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .MAX_BITS    (MAX_BITS)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (q_cmd),
        .cmd_valid (q_valid),
        .cmd_ready (back_ready),
        .m_item    (m_item),
        .m_valid   (m_valid),
        .m_ready   (m_ready)
    );

`ifndef SYNTHESIS
    // input stalls only when commands are waiting for the engine
    a_stall_means_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> q_valid)
        else $error("input stalled with empty command queue");

    // an accepted beat is queued at the next edge
    a_accept_queued: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> q_valid)
        else $error("accepted beat missing from command queue");

    // engine goes busy right after taking a command
    a_engine_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (q_valid && back_ready) |=> !back_ready)
        else $error("engine idle after taking a command");
`endif

endmodule
